@@ hw/rtl/ecq_pkg.sv @@
// Shared types, constants and arithmetic helpers for the Euler-to-quaternion block.
package ecq_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 14;
	localparam int OUT_BITS   = FRAC_BITS + 2;
	localparam int QBITS      = 30;
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_PER_STAGE = 2;
	localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER_STAGE;
	localparam int MATH_STAGES = 6;
	localparam int LATENCY = CORDIC_STAGES + MATH_STAGES;
	localparam int QW = 32;	// Q30 value width
	localparam int ZW = 34;	// CORDIC phase width
	localparam int WW = 66;	// wide accumulator width

	localparam logic signed [QW-1:0] CORDIC_K = 32'sd652032874;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] roll_angle;
		logic signed [ANGLE_BITS-1:0] pitch_angle;
		logic signed [ANGLE_BITS-1:0] yaw_angle;
	} in_word_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] quat_w;
		logic signed [OUT_BITS-1:0] quat_x;
		logic signed [OUT_BITS-1:0] quat_y;
		logic signed [OUT_BITS-1:0] quat_z;
		logic signed [OUT_BITS-1:0] grav_x;
		logic signed [OUT_BITS-1:0] grav_y;
		logic signed [OUT_BITS-1:0] grav_z;
	} out_word_t;

	// atan(2^-i), 2^31 = pi
	function automatic logic signed [ZW-1:0] atan_val(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd536870912;
			1: r = 34'sd316933406;
			2: r = 34'sd167458907;
			3: r = 34'sd85004756;
			4: r = 34'sd42667331;
			5: r = 34'sd21354465;
			6: r = 34'sd10679838;
			7: r = 34'sd5340245;
			8: r = 34'sd2670163;
			9: r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q30 x Q30 -> Q30, round half up
	function automatic logic signed [QW-1:0] mul_q(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [2*QW-1:0] p;
		logic signed [2*QW-1:0] r;
		p = a * b;
		r = (p + (64'sd1 <<< (QBITS - 1))) >>> QBITS;
		return r[QW-1:0];
	endfunction

	// round half up by s bits, saturate to +-1.0
	function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [WW-1:0] v,
			input int s);
		logic signed [WW-1:0] r;
		logic signed [WW-1:0] lim;
		lim = 66'sd1 <<< FRAC_BITS;
		r = (v + (66'sd1 <<< (s - 1))) >>> s;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r[OUT_BITS-1:0];
	endfunction

endpackage

@@ hw/rtl/ecq_cordic.sv @@
// Pipelined CORDIC rotator giving cosine and sine of half a binary angle in Q30.
module ecq_cordic import ecq_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [ANGLE_BITS-1:0] angle,
	output logic signed [QW-1:0]         cos_q,
	output logic signed [QW-1:0]         sin_q
);

	logic signed [QW-1:0] x_s [0:CORDIC_STAGES];
	logic signed [QW-1:0] y_s [0:CORDIC_STAGES];
	logic signed [ZW-1:0] z_s [0:CORDIC_STAGES];

	// half angle on the 2^31 = pi scale
	always_comb begin
		x_s[0] = CORDIC_K;
		y_s[0] = '0;
		z_s[0] = ZW'(angle) <<< (31 - ANGLE_BITS);
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		logic signed [QW-1:0] xn;
		logic signed [QW-1:0] yn;
		logic signed [ZW-1:0] zn;

		always_comb begin
			logic signed [QW-1:0] xt;
			logic signed [QW-1:0] yt;
			logic signed [ZW-1:0] zt;
			logic signed [QW-1:0] dx;
			logic signed [QW-1:0] dy;
			xt = x_s[g];
			yt = y_s[g];
			zt = z_s[g];
			for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
				dx = yt >>> (g * CORDIC_PER_STAGE + k);
				dy = xt >>> (g * CORDIC_PER_STAGE + k);
				if (zt >= 0) begin
					xt = xt - dx;
					yt = yt + dy;
					zt = zt - atan_val(g * CORDIC_PER_STAGE + k);
				end else begin
					xt = xt + dx;
					yt = yt - dy;
					zt = zt + atan_val(g * CORDIC_PER_STAGE + k);
				end
			end
			xn = xt;
			yn = yt;
			zn = zt;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g+1] <= xn;
				y_s[g+1] <= yn;
				z_s[g+1] <= zn;
			end
		end
	end

	assign cos_q = x_s[CORDIC_STAGES];
	assign sin_q = y_s[CORDIC_STAGES];

endmodule

@@ hw/rtl/ecq_math.sv @@
// Quaternion products, projected gravity and output rounding, six register stages.
module ecq_math import ecq_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [QW-1:0] cr,
	input  logic signed [QW-1:0] sr,
	input  logic signed [QW-1:0] cp,
	input  logic signed [QW-1:0] sp,
	input  logic signed [QW-1:0] cy,
	input  logic signed [QW-1:0] sy,
	output out_word_t            result_word
);

	logic signed [QW-1:0] ccp_s1, ssp_s1, scp_s1, csp_s1, cy_s1, sy_s1;
	logic signed [QW-1:0] p_s2 [0:7];
	logic signed [QW-1:0] w_s3, x_s3, y_s3, z_s3;
	logic signed [2*QW-1:0] wy_s4, xz_s4, wx_s4, yz_s4, xx_s4, yy_s4;
	logic signed [OUT_BITS-1:0] qw_s4, qx_s4, qy_s4, qz_s4;
	logic signed [OUT_BITS-1:0] qw_s5, qx_s5, qy_s5, qz_s5;
	logic signed [WW-1:0] gx_s5, gy_s5, gz_s5;
	out_word_t res_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ccp_s1 <= mul_q(cr, cp);
			ssp_s1 <= mul_q(sr, sp);
			scp_s1 <= mul_q(sr, cp);
			csp_s1 <= mul_q(cr, sp);
			cy_s1  <= cy;
			sy_s1  <= sy;

			p_s2[0] <= mul_q(ccp_s1, cy_s1);
			p_s2[1] <= mul_q(ssp_s1, sy_s1);
			p_s2[2] <= mul_q(scp_s1, cy_s1);
			p_s2[3] <= mul_q(csp_s1, sy_s1);
			p_s2[4] <= mul_q(csp_s1, cy_s1);
			p_s2[5] <= mul_q(scp_s1, sy_s1);
			p_s2[6] <= mul_q(ccp_s1, sy_s1);
			p_s2[7] <= mul_q(ssp_s1, cy_s1);

			w_s3 <= p_s2[0] + p_s2[1];
			x_s3 <= p_s2[2] - p_s2[3];
			y_s3 <= p_s2[4] + p_s2[5];
			z_s3 <= p_s2[6] - p_s2[7];

			wy_s4 <= w_s3 * y_s3;
			xz_s4 <= x_s3 * z_s3;
			wx_s4 <= w_s3 * x_s3;
			yz_s4 <= y_s3 * z_s3;
			xx_s4 <= x_s3 * x_s3;
			yy_s4 <= y_s3 * y_s3;
			qw_s4 <= to_out(WW'(w_s3), QBITS - FRAC_BITS);
			qx_s4 <= to_out(WW'(x_s3), QBITS - FRAC_BITS);
			qy_s4 <= to_out(WW'(y_s3), QBITS - FRAC_BITS);
			qz_s4 <= to_out(WW'(z_s3), QBITS - FRAC_BITS);

			gx_s5 <= WW'(wy_s4) - WW'(xz_s4);
			gy_s5 <= -(WW'(wx_s4) + WW'(yz_s4));
			gz_s5 <= ((WW'(xx_s4) + WW'(yy_s4)) <<< 1) - (66'sd1 <<< (2 * QBITS));
			qw_s5 <= qw_s4;
			qx_s5 <= qx_s4;
			qy_s5 <= qy_s4;
			qz_s5 <= qz_s4;

			res_s6.quat_w <= qw_s5;
			res_s6.quat_x <= qx_s5;
			res_s6.quat_y <= qy_s5;
			res_s6.quat_z <= qz_s5;
			res_s6.grav_x <= to_out(gx_s5, 2 * QBITS - FRAC_BITS - 1);
			res_s6.grav_y <= to_out(gy_s5, 2 * QBITS - FRAC_BITS - 1);
			res_s6.grav_z <= to_out(gz_s5, 2 * QBITS - FRAC_BITS);
		end
	end

	assign result_word = res_s6;

endmodule

@@ hw/rtl/euler_to_quat_projected_gravity.sv @@
// Top level: Euler ZYX angles to quaternion and body-frame projected gravity.
// Takes one attitude word per cycle while not stalled and returns one result
// word per sample, in order, through 12 stages of the three parallel
// CORDIC rotators (two iterations each) and 6 stages of products, sums and
// rounding. A result stall while a result is valid holds the whole pipeline,
// and the input stall follows it in the same cycle; bubbles pass through unchanged.
module euler_to_quat_projected_gravity import ecq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_stall,
	input  in_word_t  sample,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result
);

	logic en;
	logic [LATENCY-1:0] vld_q;
	logic signed [QW-1:0] cr, sr, cp, sp, cy, sy;

	assign en = !(vld_q[LATENCY-1] && result_stall);
	assign sample_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LATENCY-2:0], sample_valid};
		end
	end

	ecq_cordic u_roll (
		.clk(clk), .en(en), .angle(sample.roll_angle), .cos_q(cr), .sin_q(sr)
	);
	ecq_cordic u_pitch (
		.clk(clk), .en(en), .angle(sample.pitch_angle), .cos_q(cp), .sin_q(sp)
	);
	ecq_cordic u_yaw (
		.clk(clk), .en(en), .angle(sample.yaw_angle), .cos_q(cy), .sin_q(sy)
	);

	ecq_math u_math (
		.clk(clk), .en(en),
		.cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
		.result_word(result)
	);

	assign result_valid = vld_q[LATENCY-1];

endmodule

@@ dv/tb_euler_to_quat_projected_gravity.sv @@
// Testbench for euler_to_quat_projected_gravity: CORDIC quaternion predictor and result checker.
`timescale 1ns / 1ps

class attitude_scoreboard;
	ecq_pkg::out_word_t pending[$];
	int mismatches = 0;

	static function longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	static function longint rshift(longint v, int s);
		if (s == 0)
			return v;
		return fshift(v + (64'sd1 <<< (s - 1)), s);
	endfunction

	static function longint mq(longint a, longint b);
		return rshift(a * b, ecq_pkg::QBITS);
	endfunction

	static function logic [15:0] sat_out(longint v, int s);
		longint r;
		longint lim;
		r = rshift(v, s);
		lim = 64'sd1 <<< ecq_pkg::FRAC_BITS;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r[15:0];
	endfunction

	static function void half_rot(logic signed [15:0] ang, output longint c, output longint s);
		longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
			20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		x = 652032874;
		y = 0;
		z = longint'(ang) * (64'sd1 <<< (31 - ecq_pkg::ANGLE_BITS));
		for (int i = 0; i < 24; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= tab[i];
			end else begin
				x += dx; y -= dy; z += tab[i];
			end
		end
		c = x;
		s = y;
	endfunction

	function void note_sample(ecq_pkg::in_word_t a);
		longint cr, sr, cp, sp, cy, sy, ccp, ssp, scp, csp, w, x, y, z, gx, gy, gz;
		ecq_pkg::out_word_t e;
		half_rot(a.roll_angle, cr, sr);
		half_rot(a.pitch_angle, cp, sp);
		half_rot(a.yaw_angle, cy, sy);
		ccp = mq(cr, cp); ssp = mq(sr, sp); scp = mq(sr, cp); csp = mq(cr, sp);
		w = mq(ccp, cy) + mq(ssp, sy);
		x = mq(scp, cy) - mq(csp, sy);
		y = mq(csp, cy) + mq(scp, sy);
		z = mq(ccp, sy) - mq(ssp, cy);
		gx = w * y - x * z;
		gy = -(w * x + y * z);
		gz = 2 * (x * x + y * y) - (64'sd1 <<< 60);
		e.quat_w = sat_out(w, 16);
		e.quat_x = sat_out(x, 16);
		e.quat_y = sat_out(y, 16);
		e.quat_z = sat_out(z, 16);
		e.grav_x = sat_out(gx, 45);
		e.grav_y = sat_out(gy, 45);
		e.grav_z = sat_out(gz, 46);
		pending = {pending, e};
	endfunction

	function void check_result(ecq_pkg::out_word_t got);
		ecq_pkg::out_word_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word %h", got);
			return;
		end
		e = pending.pop_front();
		if (got !== e) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: exp w%0d x%0d y%0d z%0d g%0d,%0d,%0d",
					e.quat_w, e.quat_x, e.quat_y, e.quat_z, e.grav_x, e.grav_y, e.grav_z,
					" got w%0d x%0d y%0d z%0d g%0d,%0d,%0d",
					got.quat_w, got.quat_x, got.quat_y, got.quat_z, got.grav_x,
					got.grav_y, got.grav_z);
		end
	endfunction
endclass

module tb_euler_to_quat_projected_gravity;
	import ecq_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic sample_valid = 0;
	logic sample_stall;
	in_word_t sample = '0;
	logic result_valid;
	logic result_stall = 0;
	out_word_t result;

	attitude_scoreboard sb = new();
	bit calm = 0;
	bit sending_done = 0;
	int idle_cycles = 0;

	euler_to_quat_projected_gravity uut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic logic [15:0] pick_angle();
		logic [15:0] v[8] = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000,
			16'h0001, 16'hffff, 16'h2000};
		if ($urandom_range(0, 3) == 0)
			return v[$urandom_range(0, 7)];
		return 16'($urandom());
	endfunction

	task automatic send_word(in_word_t w);
		while (!calm && $urandom_range(0, 99) < 28) begin
			sample_valid <= 0;
			@(posedge clk);
		end
		sample_valid <= 1;
		sample <= w;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				sb.note_sample(sample);
			if (result_valid && !result_stall)
				sb.check_result(result);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			result_stall <= !calm && ($urandom_range(0, 99) < 28);
			if (idle_cycles > 2000) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] d[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'hffff};
		in_word_t w;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 24; i++) begin
			w.roll_angle = d[i % 6];
			w.pitch_angle = d[(i / 6) % 6];
			w.yaw_angle = d[(i * 5 + 1) % 6];
			send_word(w);
		end
		for (int i = 0; i < 1200; i++) begin
			calm = (i >= 500 && i < 700);
			w.roll_angle = pick_angle();
			w.pitch_angle = pick_angle();
			w.yaw_angle = pick_angle();
			send_word(w);
		end
		sample_valid <= 0;
		calm = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

@@ filelist.f @@
hw/rtl/ecq_pkg.sv
hw/rtl/ecq_cordic.sv
hw/rtl/ecq_math.sv
hw/rtl/euler_to_quat_projected_gravity.sv
dv/tb_euler_to_quat_projected_gravity.sv
